FILE: design/at_response_token_matcher_core_macros.svh
`ifndef AT_RESPONSE_TOKEN_MATCHER_CORE_MACROS_SVH
`define AT_RESPONSE_TOKEN_MATCHER_CORE_MACROS_SVH

// same-cycle implication on clk, disabled in reset
`define ATRTM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, disabled in reset
`define ATRTM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/atrtm_pkg.sv
package atrtm_pkg;

    localparam int LINE_CAPACITY = 128;
    localparam int TOKEN_BYTES   = 8;
    localparam int WIN_DEPTH     = (TOKEN_BYTES > 5) ? TOKEN_BYTES : 5;
    localparam int CNT_W         = $clog2(LINE_CAPACITY);
    localparam int TLEN_W        = 4;
    localparam int TOKEN_W       = 64;
    localparam int TIMEOUT_W     = 16;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CNT_W-1:0] LINE_LIMIT = CNT_W'(LINE_CAPACITY - 1);

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [1:0] OUT_TOKEN   = 2'd0;
    localparam logic [1:0] OUT_FAIL    = 2'd1;
    localparam logic [1:0] OUT_TIMEOUT = 2'd2;

    localparam logic [1:0] CFG_TOKEN   = 2'd0;
    localparam logic [1:0] CFG_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [7:0] CH_PROMPT = 8'h3E;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [TOKEN_W-1:0] TOKEN_RESET   = TOKEN_W'(64'h4B4F);
    localparam logic [TLEN_W-1:0]  LENGTH_RESET  = TLEN_W'(2);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(500);

    typedef enum logic [2:0] {
        KIND_START,
        KIND_TICK,
        KIND_PROMPT,
        KIND_EOL,
        KIND_DATA,
        KIND_NONE
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } entry_t;

    typedef struct packed {
        logic waiting;
        logic pop;
    } back_status_t;

    // token length after clamping and cut at the first zero byte
    function automatic logic [TLEN_W-1:0] eff_len(input logic [TOKEN_W-1:0] tok,
                                                   input logic [TLEN_W-1:0] len);
        logic [TLEN_W-1:0] n;
        logic [TLEN_W-1:0] r;
        n = (len > TLEN_W'(TOKEN_BYTES)) ? TLEN_W'(TOKEN_BYTES) : len;
        r = n;
        for (int i = TOKEN_BYTES - 1; i >= 0; i--) begin
            if (TLEN_W'(i) < n && tok[i*8 +: 8] == 8'd0) begin
                r = TLEN_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic prompt_in_token(input logic [TOKEN_W-1:0] tok,
                                             input logic [TLEN_W-1:0] len);
        logic [TLEN_W-1:0] n;
        logic hit;
        n   = eff_len(tok, len);
        hit = 1'b0;
        for (int i = 0; i < TOKEN_BYTES; i++) begin
            if (TLEN_W'(i) < n && tok[i*8 +: 8] == CH_PROMPT) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

FILE: design/atrtm_front.sv
module atrtm_front (
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       req_type,
    input  logic [7:0]                       rx_byte,
    input  logic [atrtm_pkg::TOKEN_W-1:0]    token,
    input  logic [atrtm_pkg::TLEN_W-1:0]     token_len,
    input  logic                             q_ready,
    output logic                             push,
    output atrtm_pkg::entry_t                entry
);

    logic prompt_hit;

    assign prompt_hit = atrtm_pkg::prompt_in_token(token, token_len);

    always_comb
    begin
        entry.data = rx_byte;
        case (req_type)
            atrtm_pkg::REQ_START: entry.kind = atrtm_pkg::KIND_START;
            atrtm_pkg::REQ_TICK:  entry.kind = atrtm_pkg::KIND_TICK;
            atrtm_pkg::REQ_BYTE:
            begin
                if (rx_byte == atrtm_pkg::CH_PROMPT) begin
                    entry.kind = prompt_hit ? atrtm_pkg::KIND_PROMPT : atrtm_pkg::KIND_NONE;
                end else if (rx_byte == atrtm_pkg::CH_CR || rx_byte == atrtm_pkg::CH_LF) begin
                    entry.kind = atrtm_pkg::KIND_EOL;
                end else begin
                    entry.kind = atrtm_pkg::KIND_DATA;
                end
            end
            default:              entry.kind = atrtm_pkg::KIND_NONE;
        endcase
    end

    // items with no effect are taken and dropped here
    assign in_ready = q_ready;
    assign push     = in_valid && q_ready && (entry.kind != atrtm_pkg::KIND_NONE);

endmodule

FILE: design/atrtm_queue.sv
module atrtm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  atrtm_pkg::entry_t   push_entry,
    output logic                push_ready,
    input  logic                pop,
    output logic                pop_valid,
    output atrtm_pkg::entry_t   pop_entry
);

    localparam int PTR_W = (atrtm_pkg::QUEUE_DEPTH > 1) ? $clog2(atrtm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_Q = $clog2(atrtm_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(atrtm_pkg::QUEUE_DEPTH - 1);

    atrtm_pkg::entry_t mem [atrtm_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_Q-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_Q'(atrtm_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != CNT_Q'(0));
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? PTR_W'(0) : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? PTR_W'(0) : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_Q'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_Q'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: design/atrtm_back.sv
module atrtm_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  atrtm_pkg::entry_t                  q_entry,
    output logic                               q_pop,
    input  logic [atrtm_pkg::TOKEN_W-1:0]      token,
    input  logic [atrtm_pkg::TLEN_W-1:0]       token_len,
    input  logic [atrtm_pkg::TIMEOUT_W-1:0]    timeout_ticks,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         outcome,
    output atrtm_pkg::back_status_t            status
);

    localparam int CW = atrtm_pkg::CNT_W;
    localparam int TW = atrtm_pkg::TIMEOUT_W;
    localparam int LW = atrtm_pkg::TLEN_W;
    localparam int WD = atrtm_pkg::WIN_DEPTH;
    localparam int TB = atrtm_pkg::TOKEN_BYTES;
    localparam int IW = $clog2(TB);

    logic            waiting_reg, waiting_next;
    logic [TW-1:0]   elapsed_reg, elapsed_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            hidden_reg, hidden_next;
    logic [7:0]      win_reg [WD];
    logic [7:0]      win_next [WD];
    logic            fail_reg, fail_next;
    logic            tok_reg, tok_next;
    logic            out_valid_reg, out_valid_next;
    logic [1:0]      outcome_reg, outcome_next;

    logic [7:0]      shifted [WD];
    logic [7:0]      tok_bytes [TB];
    logic [LW-1:0]   tlen;
    logic            err_hit, fail_hit, tok_hit;
    logic            res_valid;
    logic [1:0]      res_code;
    logic [TW-1:0]   tick_sum;

    assign tlen = atrtm_pkg::eff_len(token, token_len);
    assign q_pop = q_valid && (!out_valid_reg || out_ready);
    assign tick_sum = elapsed_reg + TW'(1);

    always_comb
    begin
        for (int i = 0; i < TB; i++) begin
            tok_bytes[i] = token[i*8 +: 8];
        end
        shifted[0] = q_entry.data;
        for (int j = 1; j < WD; j++) begin
            shifted[j] = win_reg[j-1];
        end
    end

    // window compares; shifted[0] is the newest byte
    always_comb
    begin
        err_hit  = shifted[4] == "E" && shifted[3] == "R" && shifted[2] == "R" &&
                   shifted[1] == "O" && shifted[0] == "R";
        fail_hit = shifted[3] == "F" && shifted[2] == "A" && shifted[1] == "I" &&
                   shifted[0] == "L";
        tok_hit  = 1'b1;
        for (int j = 0; j < TB; j++) begin
            if (LW'(j) < tlen &&
                shifted[j] != tok_bytes[IW'(tlen - LW'(1) - LW'(j))]) begin
                tok_hit = 1'b0;
            end
        end
    end

    always_comb
    begin
        waiting_next = waiting_reg;
        elapsed_next = elapsed_reg;
        count_next   = count_reg;
        hidden_next  = hidden_reg;
        win_next     = win_reg;
        fail_next    = fail_reg;
        tok_next     = tok_reg;
        res_valid    = 1'b0;
        res_code     = atrtm_pkg::OUT_TOKEN;

        if (q_pop) begin
            if (q_entry.kind == atrtm_pkg::KIND_START) begin
                count_next   = '0;
                hidden_next  = 1'b0;
                fail_next    = 1'b0;
                tok_next     = 1'b0;
                elapsed_next = '0;
                for (int j = 0; j < WD; j++) begin
                    win_next[j] = 8'd0;
                end
                if (timeout_ticks == TW'(0)) begin
                    waiting_next = 1'b0;
                    res_valid    = 1'b1;
                    res_code     = atrtm_pkg::OUT_TIMEOUT;
                end else begin
                    waiting_next = 1'b1;
                end
            end else if (waiting_reg) begin
                case (q_entry.kind)
                    atrtm_pkg::KIND_TICK:
                    begin
                        elapsed_next = tick_sum;
                        if (tick_sum >= timeout_ticks) begin
                            waiting_next = 1'b0;
                            res_valid    = 1'b1;
                            res_code     = atrtm_pkg::OUT_TIMEOUT;
                        end
                    end
                    atrtm_pkg::KIND_PROMPT:
                    begin
                        waiting_next = 1'b0;
                        res_valid    = 1'b1;
                        res_code     = atrtm_pkg::OUT_TOKEN;
                    end
                    atrtm_pkg::KIND_EOL:
                    begin
                        if (fail_reg) begin
                            waiting_next = 1'b0;
                            res_valid    = 1'b1;
                            res_code     = atrtm_pkg::OUT_FAIL;
                        end else if (tok_reg) begin
                            waiting_next = 1'b0;
                            res_valid    = 1'b1;
                            res_code     = atrtm_pkg::OUT_TOKEN;
                        end else begin
                            count_next  = '0;
                            hidden_next = 1'b0;
                            fail_next   = 1'b0;
                            tok_next    = 1'b0;
                            for (int j = 0; j < WD; j++) begin
                                win_next[j] = 8'd0;
                            end
                        end
                    end
                    atrtm_pkg::KIND_DATA:
                    begin
                        if (count_reg < atrtm_pkg::LINE_LIMIT) begin
                            count_next = count_reg + CW'(1);
                            if (!hidden_reg) begin
                                if (q_entry.data == 8'd0) begin
                                    hidden_next = 1'b1;
                                end else begin
                                    win_next = shifted;
                                    if (err_hit || fail_hit) begin
                                        fail_next = 1'b1;
                                    end
                                    if (tok_hit) begin
                                        tok_next = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        out_valid_next = out_valid_reg && !out_ready;
        outcome_next   = outcome_reg;
        if (res_valid) begin
            out_valid_next = 1'b1;
            outcome_next   = res_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            waiting_reg   <= 1'b0;
            elapsed_reg   <= '0;
            count_reg     <= '0;
            hidden_reg    <= 1'b0;
            fail_reg      <= 1'b0;
            tok_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < WD; j++) begin
                win_reg[j] <= 8'd0;
            end
        end else begin
            waiting_reg   <= waiting_next;
            elapsed_reg   <= elapsed_next;
            count_reg     <= count_next;
            hidden_reg    <= hidden_next;
            fail_reg      <= fail_next;
            tok_reg       <= tok_next;
            out_valid_reg <= out_valid_next;
            win_reg       <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        outcome_reg <= outcome_next;
    end

    assign out_valid      = out_valid_reg;
    assign outcome        = outcome_reg;
    assign status.waiting = waiting_reg;
    assign status.pop     = q_pop;

endmodule

FILE: design/at_response_token_matcher_core.sv
// Response matcher for a command/response modem link. Takes one item per clock while
// in_ready is high (start, received byte or 10 ms tick) and gives at most one outcome per item:
// token found, ERROR/FAIL line, or timeout. An item passes a classify stage and a
// two-entry queue, then the match engine, which updates its state and window and
// registers an outcome at the same edge at which it takes the item from the queue;
// the item is thus registered first in the queue and then in the outcome register.
// in_ready drops only when the queue is full, which happens only while an outcome
// waits on out_ready. Configuration writes are taken every cycle (cfg_ready stays high).
`include "at_response_token_matcher_core_macros.svh"

module at_response_token_matcher_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [atrtm_pkg::TOKEN_W-1:0]      cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         req_type,
    input  logic [7:0]                         rx_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         outcome
);

    logic [atrtm_pkg::TOKEN_W-1:0]   token_reg;
    logic [atrtm_pkg::TLEN_W-1:0]    length_reg;
    logic [atrtm_pkg::TIMEOUT_W-1:0] timeout_reg;

    logic                    push;
    logic                    q_ready;
    logic                    q_valid;
    logic                    q_pop;
    atrtm_pkg::entry_t       push_entry;
    atrtm_pkg::entry_t       q_entry;
    atrtm_pkg::back_status_t back_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            token_reg   <= atrtm_pkg::TOKEN_RESET;
            length_reg  <= atrtm_pkg::LENGTH_RESET;
            timeout_reg <= atrtm_pkg::TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                atrtm_pkg::CFG_TOKEN:   token_reg   <= cfg_data;
                atrtm_pkg::CFG_LENGTH:  length_reg  <= cfg_data[atrtm_pkg::TLEN_W-1:0];
                atrtm_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data[atrtm_pkg::TIMEOUT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    atrtm_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .rx_byte   (rx_byte),
        .token     (token_reg),
        .token_len (length_reg),
        .q_ready   (q_ready),
        .push      (push),
        .entry     (push_entry)
    );

    atrtm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    atrtm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .token         (token_reg),
        .token_len     (length_reg),
        .timeout_ticks (timeout_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .outcome       (outcome),
        .status        (back_status)
    );

    `ATRTM_ASSERT_NOW(a_result_ends_wait, out_valid, !back_status.waiting, "outcome pending while still waiting")
    `ATRTM_ASSERT_NOW(a_pop_only_when_free, back_status.pop, (!out_valid || out_ready), "engine took item while output stalled")
    `ATRTM_ASSERT_NEXT(a_push_lands, (push && in_ready), q_valid, "pushed item missing from queue")
    `ATRTM_ASSERT_NOW(a_outcome_code, out_valid, (outcome == atrtm_pkg::OUT_TOKEN || outcome == atrtm_pkg::OUT_FAIL || outcome == atrtm_pkg::OUT_TIMEOUT), "bad outcome code")

endmodule
